// ===== design/round_robin_task_scheduler_assert.svh =====
// Assertion macros for the round-robin task scheduler.
`ifndef ROUND_ROBIN_TASK_SCHEDULER_ASSERT_SVH
`define ROUND_ROBIN_TASK_SCHEDULER_ASSERT_SVH

// Same-cycle implication, sampled on aclk, off during reset.
`define RRTS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off during reset.
`define RRTS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/rrts_pkg.sv =====
// Shared types, codes and constants of the round-robin task scheduler.
`default_nettype none

package rrts_pkg;

    localparam int ID_W  = 6;
    localparam int CNT_W = 7;
    localparam int SL_W  = 16;
    localparam int TOT_W = 32;
    localparam int PCT_W = 7;

    localparam int DEF_MAX_TASKS = 64;

    localparam logic [SL_W-1:0] RESET_SLICE_LEN = 16'd10;
    localparam logic [ID_W-1:0] RESET_IDLE_ID   = 6'd0;

    localparam logic [PCT_W-1:0] LOAD_FULL = 7'd100;
    localparam logic [PCT_W-1:0] LOAD_LOW  = 7'd40;
    localparam logic [PCT_W-1:0] LOAD_MID  = 7'd80;
    localparam logic [PCT_W-1:0] LOAD_HIGH = 7'd95;

    localparam logic [2:0] ACT_TICK   = 3'd0;
    localparam logic [2:0] ACT_ADD    = 3'd1;
    localparam logic [2:0] ACT_YIELD  = 3'd2;
    localparam logic [2:0] ACT_END    = 3'd3;
    localparam logic [2:0] ACT_STOP   = 3'd4;
    localparam logic [2:0] ACT_RESUME = 3'd5;
    localparam logic [2:0] ACT_REAP   = 3'd6;
    localparam logic [2:0] ACT_LOAD   = 3'd7;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOT_RDY = 2'd1;
    localparam logic [1:0] ST_QUEUED  = 2'd2;

    localparam logic [1:0] M_NONE  = 2'd0;
    localparam logic [1:0] M_READY = 2'd1;
    localparam logic [1:0] M_WAIT  = 2'd2;

    localparam logic [7:0] CFG_SLICE = 8'd0;
    localparam logic [7:0] CFG_IDLE  = 8'd1;

    typedef struct packed {
        logic [ID_W-1:0]  head;
        logic [ID_W-1:0]  tail;
        logic [CNT_W-1:0] len;
    } list_t;

    typedef struct packed {
        logic             start;
        logic [TOT_W-1:0] di;
        logic [TOT_W-1:0] dt;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [PCT_W-1:0] q;
    } div_rsp_t;

    function automatic logic [1:0] halt_hint(logic [PCT_W-1:0] load);
        logic [1:0] h;
        if (load < LOAD_LOW) h = 2'd3;
        else if (load < LOAD_MID) h = 2'd2;
        else if (load < LOAD_HIGH) h = 2'd1;
        else h = 2'd0;
        return h;
    endfunction

endpackage

`default_nettype wire

// ===== design/rrts_load_div.sv =====
// Load divider: di*100/dt by multiply then one restoring step per cycle.
`default_nettype none

module rrts_load_div
    import rrts_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);

    localparam int NW = TOT_W + PCT_W;

    logic             busy_reg;
    logic             done_reg;
    logic [2:0]       k_reg;
    logic [NW-1:0]    rem_reg;
    logic [TOT_W-1:0] d_reg;
    logic [PCT_W-1:0] q_reg;

    logic [NW-1:0] dsh;
    logic [NW:0]   trial;

    assign dsh   = NW'(d_reg) << k_reg;
    assign trial = {1'b0, rem_reg} - {1'b0, dsh};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= busy_reg && (k_reg == 3'd0);
            if (req.start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && (k_reg == 3'd0)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg <= NW'(req.di) * NW'(LOAD_FULL);
            d_reg   <= req.dt;
            k_reg   <= 3'd6;
            q_reg   <= '0;
        end else if (busy_reg) begin
            if (!trial[NW]) begin
                rem_reg <= trial[NW-1:0];
                q_reg[k_reg] <= 1'b1;
            end
            k_reg <= k_reg - 3'd1;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.q    = q_reg;

endmodule

`default_nettype wire

// ===== design/round_robin_task_scheduler.sv =====
// Round-robin task scheduler top level: list sequencer, stores and ports.
//
// One word is taken on s_axis when s_axis_tready is high; its result word
// appears on m_axis from an output register, so the next word can enter
// while a result still waits. Tick, add, yield, end and stop take one
// sequencer pass, plus a registered read of the link store where a list
// changes. Resume and reap walk the waiting list through the one read port
// of the link store. Measure load runs one multiply and seven restoring
// divide steps in the divider, or skips it when no tick has elapsed or the
// idle time exceeds the ticks. A result held by m_axis_tready low adds its
// stall to the next word's time. After reset a clearing pass sweeps the
// membership store before the first word is taken; configuration writes
// are taken at any time.
`default_nettype none

module round_robin_task_scheduler
    import rrts_pkg::*;
#(
    parameter int MAX_TASKS = DEF_MAX_TASKS
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,  // action[2:0], task_id[8:3], zero fill
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [47:0]      m_axis_tdata,  // running_id[5:0], switched[6], status[8:7],
                                            // busy_pct[15:9], halt_count[17:16],
                                            // ready_count[24:18], waiting_count[31:25],
                                            // slice_left[47:32]
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

`include "round_robin_task_scheduler_assert.svh"

    localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

    localparam logic [3:0] S_CLR      = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_DISP     = 4'd2;
    localparam logic [3:0] S_ADD      = 4'd3;
    localparam logic [3:0] S_END_CHK  = 4'd4;
    localparam logic [3:0] S_END_PUSH = 4'd5;
    localparam logic [3:0] S_SW_RD    = 4'd6;
    localparam logic [3:0] S_SW_DO    = 4'd7;
    localparam logic [3:0] S_STOP_DO  = 4'd8;
    localparam logic [3:0] S_RES_RD   = 4'd9;
    localparam logic [3:0] S_RES_DO   = 4'd10;
    localparam logic [3:0] S_REAP_RD  = 4'd11;
    localparam logic [3:0] S_REAP_DO  = 4'd12;
    localparam logic [3:0] S_DIV      = 4'd13;
    localparam logic [3:0] S_OUT      = 4'd14;

    logic [3:0]       state_reg, state_next;
    logic [IW-1:0]    clr_cnt_reg, clr_cnt_next;
    logic [2:0]       act_reg, act_next;
    logic [ID_W-1:0]  id_reg, id_next;
    logic             endold_reg, endold_next;
    list_t            rl_reg, rl_next;
    list_t            wl_reg, wl_next;
    logic [ID_W-1:0]  cur_reg, cur_next;
    logic [SL_W-1:0]  slice_reg, slice_next;
    logic [TOT_W-1:0] tick_reg, tick_next;
    logic [TOT_W-1:0] idle_reg, idle_next;
    logic [TOT_W-1:0] lts_reg, lts_next;
    logic [TOT_W-1:0] lis_reg, lis_next;
    logic [PCT_W-1:0] load_reg, load_next;
    logic             sw_reg, sw_next;
    logic [1:0]       status_reg, status_next;
    logic             m_valid_reg;
    logic [47:0]      m_data_reg;
    logic [SL_W-1:0]  slice_len_reg;
    logic [ID_W-1:0]  idle_id_reg;

    logic [ID_W-1:0] nxt_mem [MAX_TASKS];
    logic [ID_W-1:0] prv_mem [MAX_TASKS];
    logic [1:0]      mb_mem  [MAX_TASKS];
    logic [ID_W-1:0] nxt_q, prv_q;
    logic [1:0]      mb_q;

    logic            nxt_we, prv_we, mb_we;
    logic [IW-1:0]   nxt_wa, prv_wa, mb_wa, rd_addr;
    logic [ID_W-1:0] nxt_wd, prv_wd;
    logic [1:0]      mb_wd;

    logic            do_push;
    list_t           pl;
    logic [ID_W-1:0] pid;
    logic [1:0]      pmark;
    logic            out_load;

    logic            id_ok, cur_ok;
    logic [SL_W-1:0] s1;
    logic [TOT_W-1:0] idle_full, idle_part, dt, di;
    list_t           nl;

    div_req_t div_req;
    div_rsp_t div_rsp;

    function automatic list_t push_list(list_t l, logic [ID_W-1:0] id);
        list_t r;
        r = l;
        if (l.len == '0) r.head = id;
        r.tail = id;
        r.len  = l.len + 7'd1;
        return r;
    endfunction

    rrts_load_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign id_ok  = 32'(id_reg) < 32'(MAX_TASKS);
    assign cur_ok = 32'(cur_reg) < 32'(MAX_TASKS);
    assign s1     = (slice_reg != '0) ? slice_reg - 16'd1 : '0;
    assign idle_full = (cur_reg == idle_id_reg) ? TOT_W'(slice_len_reg) : '0;
    assign idle_part = ((cur_reg == idle_id_reg) && (slice_len_reg > slice_reg)) ?
                       TOT_W'(slice_len_reg - slice_reg) : '0;
    assign dt = tick_reg - lts_reg;
    assign di = idle_reg - lis_reg;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign cfg_ready     = 1'b1;

    always_comb begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        act_next     = act_reg;
        id_next      = id_reg;
        endold_next  = endold_reg;
        rl_next      = rl_reg;
        wl_next      = wl_reg;
        cur_next     = cur_reg;
        slice_next   = slice_reg;
        tick_next    = tick_reg;
        idle_next    = idle_reg;
        lts_next     = lts_reg;
        lis_next     = lis_reg;
        load_next    = load_reg;
        sw_next      = sw_reg;
        status_next  = status_reg;
        nxt_we = 1'b0; nxt_wa = '0; nxt_wd = '0;
        prv_we = 1'b0; prv_wa = '0; prv_wd = '0;
        mb_we  = 1'b0; mb_wa  = '0; mb_wd  = M_NONE;
        rd_addr  = IW'(id_reg);
        do_push  = 1'b0;
        pl       = rl_reg;
        pid      = id_reg;
        pmark    = M_READY;
        out_load = 1'b0;
        nl       = rl_reg;
        div_req.start = 1'b0;
        div_req.di    = di;
        div_req.dt    = dt;

        case (state_reg)
            S_CLR: begin
                mb_we = 1'b1;
                mb_wa = clr_cnt_reg;
                mb_wd = M_NONE;
                if (clr_cnt_reg == IW'(MAX_TASKS - 1)) begin
                    state_next = S_IDLE;
                end else begin
                    clr_cnt_next = clr_cnt_reg + IW'(1);
                end
            end
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    act_next    = s_axis_tdata[2:0];
                    id_next     = s_axis_tdata[8:3];
                    sw_next     = 1'b0;
                    status_next = ST_OK;
                    endold_next = 1'b0;
                    state_next  = S_DISP;
                end
            end
            S_DISP: begin
                state_next = S_OUT;
                case (act_reg)
                    ACT_TICK: begin
                        tick_next = tick_reg + 32'd1;
                        if (s1 == '0) begin
                            idle_next  = idle_reg + idle_full;
                            slice_next = slice_len_reg;
                            if (rl_reg.len != '0) state_next = S_SW_RD;
                        end else begin
                            slice_next = s1;
                        end
                    end
                    ACT_ADD: begin
                        if (!id_ok) status_next = ST_NOT_RDY;
                        else state_next = S_ADD;
                    end
                    ACT_YIELD: begin
                        idle_next  = idle_reg + idle_part;
                        slice_next = slice_len_reg;
                        if (rl_reg.len != '0) state_next = S_SW_RD;
                    end
                    ACT_END: begin
                        if (!id_ok) begin
                            status_next = ST_NOT_RDY;
                        end else if (id_reg == cur_reg) begin
                            if (rl_reg.len == '0) begin
                                status_next = ST_NOT_RDY;
                            end else begin
                                idle_next   = idle_reg + idle_part;
                                slice_next  = slice_len_reg;
                                endold_next = 1'b1;
                                state_next  = S_SW_RD;
                            end
                        end else begin
                            state_next = S_END_CHK;
                        end
                    end
                    ACT_STOP: begin
                        if (rl_reg.len != '0) begin
                            rd_addr    = IW'(rl_reg.head);
                            state_next = S_STOP_DO;
                        end
                    end
                    ACT_RESUME: state_next = S_RES_RD;
                    ACT_REAP:   state_next = S_REAP_RD;
                    default: begin
                        if ((dt == '0) || (di > dt)) begin
                            load_next = '0;
                        end else begin
                            div_req.start = 1'b1;
                            state_next    = S_DIV;
                        end
                        lts_next = tick_reg;
                        lis_next = idle_reg;
                    end
                endcase
            end
            S_ADD: begin
                state_next = S_OUT;
                if ((id_reg == cur_reg) || (mb_q != M_NONE)) begin
                    status_next = ST_QUEUED;
                end else begin
                    do_push = 1'b1;
                    pl      = rl_reg;
                    pid     = id_reg;
                    pmark   = M_READY;
                    rl_next = push_list(rl_reg, id_reg);
                end
            end
            S_END_CHK: begin
                if (mb_q != M_READY) begin
                    status_next = ST_NOT_RDY;
                    state_next  = S_OUT;
                end else begin
                    rl_next.len = rl_reg.len - 7'd1;
                    if (id_reg == rl_reg.head) begin
                        if (rl_reg.len != 7'd1) rl_next.head = nxt_q;
                    end else if (id_reg == rl_reg.tail) begin
                        rl_next.tail = prv_q;
                    end else begin
                        nxt_we = 1'b1; nxt_wa = IW'(prv_q); nxt_wd = nxt_q;
                        prv_we = 1'b1; prv_wa = IW'(nxt_q); prv_wd = prv_q;
                    end
                    state_next = S_END_PUSH;
                end
            end
            S_END_PUSH: begin
                do_push    = 1'b1;
                pl         = wl_reg;
                pid        = id_reg;
                pmark      = M_WAIT;
                wl_next    = push_list(wl_reg, id_reg);
                state_next = S_OUT;
            end
            S_SW_RD: begin
                rd_addr    = IW'(rl_reg.head);
                state_next = S_SW_DO;
            end
            S_SW_DO: begin
                nl.len = rl_reg.len - 7'd1;
                if (nl.len != '0) nl.head = nxt_q;
                rl_next = nl;
                if (cur_ok) begin
                    do_push = 1'b1;
                    pid     = cur_reg;
                    if (endold_reg) begin
                        pl      = wl_reg;
                        pmark   = M_WAIT;
                        wl_next = push_list(wl_reg, cur_reg);
                    end else begin
                        pl      = nl;
                        pmark   = M_READY;
                        rl_next = push_list(nl, cur_reg);
                    end
                end
                cur_next   = rl_reg.head;
                sw_next    = 1'b1;
                state_next = S_OUT;
            end
            S_STOP_DO: begin
                nl.len = rl_reg.len - 7'd1;
                if (nl.len != '0) nl.head = nxt_q;
                rl_next    = nl;
                do_push    = 1'b1;
                pl         = wl_reg;
                pid        = rl_reg.head;
                pmark      = M_WAIT;
                wl_next    = push_list(wl_reg, rl_reg.head);
                state_next = S_OUT;
            end
            S_RES_RD: begin
                if (wl_reg.len == '0) begin
                    idle_next  = idle_reg + idle_part;
                    slice_next = slice_len_reg;
                    state_next = (rl_reg.len != '0) ? S_SW_RD : S_OUT;
                end else begin
                    rd_addr    = IW'(wl_reg.head);
                    state_next = S_RES_DO;
                end
            end
            S_RES_DO: begin
                wl_next.len = wl_reg.len - 7'd1;
                if (wl_reg.len != 7'd1) wl_next.head = nxt_q;
                do_push    = 1'b1;
                pl         = rl_reg;
                pid        = wl_reg.head;
                pmark      = M_READY;
                rl_next    = push_list(rl_reg, wl_reg.head);
                state_next = S_RES_RD;
            end
            S_REAP_RD: begin
                if (wl_reg.len == '0) begin
                    state_next = S_OUT;
                end else begin
                    rd_addr    = IW'(wl_reg.head);
                    state_next = S_REAP_DO;
                end
            end
            S_REAP_DO: begin
                mb_we = 1'b1;
                mb_wa = IW'(wl_reg.head);
                mb_wd = M_NONE;
                wl_next.len = wl_reg.len - 7'd1;
                if (wl_reg.len != 7'd1) wl_next.head = nxt_q;
                state_next = S_REAP_RD;
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    load_next  = LOAD_FULL - div_rsp.q;
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (!m_valid_reg || m_axis_tready) begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        if (do_push) begin
            nxt_we = (pl.len != '0); nxt_wa = IW'(pl.tail); nxt_wd = pid;
            prv_we = (pl.len != '0); prv_wa = IW'(pid);     prv_wd = pl.tail;
            mb_we  = 1'b1;           mb_wa  = IW'(pid);     mb_wd  = pmark;
        end
    end

    always_ff @(posedge aclk) begin
        if (nxt_we) nxt_mem[nxt_wa] <= nxt_wd;
        if (prv_we) prv_mem[prv_wa] <= prv_wd;
        if (mb_we)  mb_mem[mb_wa]   <= mb_wd;
        nxt_q <= nxt_mem[rd_addr];
        prv_q <= prv_mem[rd_addr];
        mb_q  <= mb_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLR;
            clr_cnt_reg   <= '0;
            rl_reg        <= '0;
            wl_reg        <= '0;
            cur_reg       <= RESET_IDLE_ID;
            slice_reg     <= '0;
            tick_reg      <= '0;
            idle_reg      <= '0;
            lts_reg       <= '0;
            lis_reg       <= '0;
            load_reg      <= '0;
            m_valid_reg   <= 1'b0;
            slice_len_reg <= RESET_SLICE_LEN;
            idle_id_reg   <= RESET_IDLE_ID;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            rl_reg      <= rl_next;
            wl_reg      <= wl_next;
            cur_reg     <= cur_next;
            slice_reg   <= slice_next;
            tick_reg    <= tick_next;
            idle_reg    <= idle_next;
            lts_reg     <= lts_next;
            lis_reg     <= lis_next;
            load_reg    <= load_next;
            m_valid_reg <= out_load || (m_valid_reg && !m_axis_tready);
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_SLICE: slice_len_reg <= cfg_data;
                    CFG_IDLE:  idle_id_reg   <= cfg_data[ID_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        act_reg    <= act_next;
        id_reg     <= id_next;
        endold_reg <= endold_next;
        sw_reg     <= sw_next;
        status_reg <= status_next;
        if (out_load) begin
            m_data_reg <= {slice_reg, wl_reg.len, rl_reg.len, halt_hint(load_reg),
                           load_reg, status_reg, sw_reg, cur_reg};
        end
    end

    `RRTS_ASSERT_NXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready,
        "scheduler took a word while busy")
    `RRTS_ASSERT_IMP(a_list_bound, state_reg == S_IDLE,
        32'(rl_reg.len) + 32'(wl_reg.len) <= 32'(MAX_TASKS), "list lengths exceed task count")
    `RRTS_ASSERT_IMP(a_div_done_state, div_rsp.done, state_reg == S_DIV,
        "divider finished outside load measurement")

endmodule

`default_nettype wire
